// ===== rtl/core/cluster_bitmap_allocator_defines.svh =====
// Assertion macros used by the cluster bitmap allocator RTL.
`ifndef CLUSTER_BITMAP_ALLOCATOR_DEFINES_SVH
`define CLUSTER_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define CBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define CBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/cba_pkg.sv =====
// Shared constants, types and helpers of the cluster bitmap allocator.
`timescale 1ns / 1ps
`default_nettype none

package cba_pkg;

    // Bitmap geometry: bytes are packed eight to a memory word
    localparam int BITMAP_BYTES  = 2048;
    localparam int WORD_BYTES    = 8;
    localparam int WORD_W        = WORD_BYTES * 8;
    localparam int WORD_SHIFT    = $clog2(WORD_W);
    localparam int ROWS          = (BITMAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int ROW_W         = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Field widths and limits
    localparam int POS_W         = 14;
    localparam int CNT_W         = 15;
    localparam int POSITION_SPAN = 16384;
    localparam int STORE_BITS    = BITMAP_BYTES * 8;
    localparam int LIM_MAX       = (STORE_BITS < POSITION_SPAN) ? STORE_BITS : POSITION_SPAN;
    localparam int COUNT_RESET   = 16384;

    // Request codes
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_CLR  = 2'd1,
        OP_FIND = 2'd2
    } t_op;

    // Outcome of searching one bitmap word
    typedef struct packed {
        logic             found;
        logic             last;
        logic [POS_W-1:0] cluster;
    } t_find_res;

    // Cluster count saturated to what the store and a position can cover
    function automatic logic [CNT_W-1:0] sat_limit(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] lim;
        lim = cnt;
        if (int'(cnt) > LIM_MAX) begin
            lim = CNT_W'(LIM_MAX);
        end
        return lim;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cba_ram.sv =====
// Synchronous RAM with one write port and one read port, and registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cba_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/cba_find.sv =====
// Search of one bitmap word for the lowest free cluster below the limit.
`timescale 1ns / 1ps
`default_nettype none

module cba_find import cba_pkg::*; (
    input  wire logic [WORD_W-1:0] i_word,
    input  wire logic [ROW_W-1:0]  i_row,
    input  wire logic [CNT_W-1:0]  i_limit,
    output t_find_res              o_res
);

    logic [CNT_W-1:0]      base;
    logic [CNT_W-1:0]      rem;
    logic [WORD_W-1:0]     mask;
    logic [WORD_W-1:0]     free_bits;
    logic                  found;
    logic [WORD_SHIFT-1:0] k_sel;

    // Clusters of this row that lie below the limit; MSB is the lowest cluster
    always_comb begin
        base      = CNT_W'({i_row, {WORD_SHIFT{1'b0}}});
        rem       = i_limit - base;
        mask      = ~({WORD_W{1'b1}} >> rem);
        free_bits = ~i_word & mask;
    end

    // Priority encoder from the MSB side: lowest free cluster wins
    always_comb begin
        found = 1'b0;
        k_sel = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (free_bits[WORD_W-1-k]) begin
                found = 1'b1;
                k_sel = WORD_SHIFT'(k);
            end
        end
    end

    assign o_res.found   = found;
    assign o_res.last    = (rem <= CNT_W'(WORD_W));
    assign o_res.cluster = POS_W'({i_row, k_sel});

endmodule

`default_nettype wire

// ===== rtl/core/cluster_bitmap_allocator.sv =====
// A mark reads its row at the transfer edge, then, once the result register is free, writes it
// back and registers its result together; a refusal registers its result once that register is
// free. A find scans rows, 1 to 256, one 64-cluster row per cycle as set by the single read port.
// One request is in flight at a time; the next is taken once the result of the last is registered.
// A waiting result still lets the next one in.
// Reset (synchronous, active low) clears the per-row valid bits at once; count resets to 16384.
`timescale 1ns / 1ps
`default_nettype none

`include "cluster_bitmap_allocator_defines.svh"

module cluster_bitmap_allocator import cba_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request channel
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [1:0]       i_op,
    input  wire logic [POS_W-1:0] i_position,
    // result channel
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_ok,
    output logic      [POS_W-1:0] o_free_cluster,
    // configuration channel
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_cluster_count
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MARK = 4'b0010,
        S_SCAN = 4'b0100,
        S_REJ  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_limit;
    logic [1:0]         r_op;
    logic [POS_W-1:0]   r_pos;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_valid [ROWS];
    logic               r_rd_vld;
    logic               r_o_valid, n_o_valid;
    logic               r_o_ok, n_o_ok;
    logic [POS_W-1:0]   r_o_cluster, n_o_cluster;

    logic               accept;
    logic               out_free;
    logic               is_mark;
    logic               in_range;
    logic               rd_en;
    logic [ROW_W-1:0]   rd_addr;
    logic               we;
    logic [ROW_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_word;
    logic [WORD_W-1:0]  ram_q;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  bit_sel;
    t_find_res          fres;

    assign accept      = i_valid && o_ready;
    assign out_free    = !r_o_valid || i_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign is_mark     = (i_op == OP_SET) || (i_op == OP_CLR);
    assign in_range    = ({1'b0, i_position} < r_limit);

    // Rows never written read as all free
    assign word    = r_rd_vld ? ram_q : '0;
    assign wr_addr = ROW_W'(r_pos >> WORD_SHIFT);
    assign bit_sel = {1'b1, {(WORD_W-1){1'b0}}} >> r_pos[WORD_SHIFT-1:0];
    assign wr_word = (r_op == OP_SET) ? (word | bit_sel) : (word & ~bit_sel);

    cba_ram #(
        .DEPTH (ROWS),
        .WIDTH (WORD_W),
        .AW    (ROW_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_word),
        .i_re      (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    cba_find u_find (
        .i_word  (word),
        .i_row   (r_row),
        .i_limit (r_limit),
        .o_res   (fres)
    );

    // Control: request decode, row scan, result hand-off
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_o_valid   = r_o_valid && !i_ready;
        n_o_ok      = r_o_ok;
        n_o_cluster = r_o_cluster;
        rd_en       = 1'b0;
        rd_addr     = '0;
        we          = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_mark && in_range) begin
                        rd_en   = 1'b1;
                        rd_addr = ROW_W'(i_position >> WORD_SHIFT);
                        n_state = S_MARK;
                    end else if ((i_op == OP_FIND) && (r_limit != '0)) begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_row   = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_REJ;
                    end
                end
            end
            S_MARK: begin
                if (out_free) begin
                    we          = 1'b1;
                    n_o_valid   = 1'b1;
                    n_o_ok      = 1'b1;
                    n_o_cluster = '0;
                    n_state     = S_IDLE;
                end
            end
            S_SCAN: begin
                if (fres.found || fres.last) begin
                    if (out_free) begin
                        n_o_valid   = 1'b1;
                        n_o_ok      = fres.found;
                        n_o_cluster = fres.found ? fres.cluster : '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_row + 1'b1;
                    n_row   = r_row + 1'b1;
                end
            end
            S_REJ: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_ok      = 1'b0;
                    n_o_cluster = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_limit   <= sat_limit(CNT_W'(COUNT_RESET));
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= sat_limit(i_cfg_cluster_count);
            end
        end
    end

    // Per-row valid bits: set on first write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (we) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_pos <= i_position;
        end
        if (rd_en) begin
            r_rd_vld <= r_valid[rd_addr];
        end
        r_row       <= n_row;
        r_o_ok      <= n_o_ok;
        r_o_cluster <= n_o_cluster;
    end

    assign o_valid        = r_o_valid;
    assign o_ok           = r_o_ok;
    assign o_free_cluster = r_o_cluster;

    // Checks
    `CBA_ASSERT_IMP(a_we_in_mark, i_clk, i_rst_n, we, (r_state == S_MARK), "write outside mark")
    `CBA_ASSERT_NXT(a_read_then_use, i_clk, i_rst_n, rd_en, ((r_state == S_MARK) || (r_state == S_SCAN)), "read data not consumed")
    `CBA_ASSERT_IMP(a_find_below_limit, i_clk, i_rst_n, ((r_state == S_SCAN) && fres.found && out_free), ({1'b0, fres.cluster} < r_limit), "found cluster beyond limit")
    `CBA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, (o_valid && !o_ok), (o_free_cluster == '0), "nonzero cluster on failed request")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the cluster bitmap allocator: marks, finds and cluster count limits.
`timescale 1ns / 1ps

module testbench;
    import cba_pkg::*;

    // Unused request code: the block must answer it with a refusal
    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         DRAIN_CYCLES    = 300;

    typedef struct {
        logic             ok;
        logic [POS_W-1:0] cluster;
    } t_alloc_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [1:0]       i_op = OP_SET;
    logic [POS_W-1:0] i_position = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic             o_ok;
    logic [POS_W-1:0] o_free_cluster;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_cluster_count = CNT_W'(COUNT_RESET);

    // Shadow copy of the block state
    logic [7:0]       usage_copy [BITMAP_BYTES];
    logic [CNT_W-1:0] cluster_count_copy;
    t_alloc_result    pending_alloc_results [$];
    t_alloc_result    last_alloc;

    int fail_count    = 0;
    bit no_idle       = 1'b0;
    int hold_off_req  = 0;
    int hold_off_seen = 0;
    int ready_stall   = 0;

    cluster_bitmap_allocator uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_op                (i_op),
        .i_position          (i_position),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_ok                (o_ok),
        .o_free_cluster      (o_free_cluster),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_cluster_count (i_cfg_cluster_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Usable clusters: count saturated to what the store and a position cover
    function automatic int active_limit();
        return (int'(cluster_count_copy) > LIM_MAX) ? LIM_MAX : int'(cluster_count_copy);
    endfunction

    // Apply one accepted request to the shadow bitmap and queue its result
    task automatic predict_allocation(input logic [1:0] op, input logic [POS_W-1:0] pos);
        t_alloc_result res;
        int            lim;
        int            n;
        int            byte_idx;
        int            bit_idx;
        lim         = active_limit();
        res.ok      = 1'b0;
        res.cluster = '0;
        case (op)
            OP_SET, OP_CLR: begin
                if (int'(pos) < lim) begin
                    byte_idx = int'(pos) / 8;
                    bit_idx  = 7 - int'(pos[2:0]);
                    usage_copy[byte_idx][bit_idx] = (op == OP_SET);
                    res.ok = 1'b1;
                end
            end
            OP_FIND: begin
                // MSB of each byte is the lowest cluster
                for (n = 0; n < lim && !res.ok; n++) begin
                    if (!usage_copy[n / 8][7 - (n % 8)]) begin
                        res.ok      = 1'b1;
                        res.cluster = POS_W'(n);
                    end
                end
            end
            default: ;
        endcase
        last_alloc = res;
        pending_alloc_results.push_back(res);
    endtask

    // Offer one request after a random gap; valid stays up while items follow
    task automatic send_request(input logic [1:0] op, input logic [POS_W-1:0] pos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        predict_allocation(op, pos);
    endtask

    // Stop offering and wait until every queued result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_alloc_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cluster_count(input logic [CNT_W-1:0] count);
        wait_drained();
        i_cfg_valid         <= 1'b1;
        i_cfg_cluster_count <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        cluster_count_copy = count;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void check_result();
        t_alloc_result exp;
        if (pending_alloc_results.size() == 0) begin
            $error("result with none pending: ok=%0d free_cluster=%0d", o_ok, o_free_cluster);
            fail_count++;
        end else begin
            exp = pending_alloc_results.pop_front();
            if (o_ok !== exp.ok) begin
                $error("ok: expected %0d, actual %0d", exp.ok, o_ok);
                fail_count++;
            end
            if (o_free_cluster !== exp.cluster) begin
                $error("free_cluster: expected %0d, actual %0d", exp.cluster, o_free_cluster);
                fail_count++;
            end
        end
    endfunction

    // Result side: check each transfer, then draw the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                check_result();
                ready_stall = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (hold_off_req != hold_off_seen) begin
                hold_off_seen = hold_off_req;
                ready_stall   = HOLD_OFF_CYCLES;
            end
            if (ready_stall > 0) begin
                ready_stall = ready_stall - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Everything free after reset; top cluster set and cleared; unused code
    task automatic test_reset_defaults();
        send_request(OP_FIND, '1);
        send_request(OP_SET, POS_W'(16383));
        send_request(OP_CLR, POS_W'(16383));
        send_request(OP_UNUSED, '1);
        send_request(OP_UNUSED, '0);
    endtask

    // Fill across a byte boundary, then reopen a hole at the last bit of a byte
    task automatic test_byte_boundary();
        int k;
        for (k = 0; k <= 8; k++) send_request(OP_SET, POS_W'(k));
        send_request(OP_CLR, POS_W'(7));
        send_request(OP_FIND, '0);
    endtask

    // Smallest, zero and largest cluster counts
    task automatic test_count_extremes();
        write_cluster_count(CNT_W'(1));
        send_request(OP_SET, POS_W'(0));
        send_request(OP_SET, POS_W'(1));
        send_request(OP_FIND, '0);
        send_request(OP_CLR, POS_W'(0));
        send_request(OP_FIND, '0);
        write_cluster_count('0);
        send_request(OP_SET, POS_W'(0));
        send_request(OP_FIND, '0);
        write_cluster_count('1);
        send_request(OP_SET, POS_W'(16383));
        send_request(OP_FIND, '0);
        write_cluster_count(CNT_W'(COUNT_RESET));
    endtask

    // Receiver holds off while requests keep coming, then a full drain pause
    task automatic test_backpressure();
        int k;
        hold_off_req <= hold_off_req + 1;
        no_idle = 1'b1;
        for (k = 0; k < 12; k++) begin
            send_request((k % 3 == 0) ? OP_FIND : OP_SET, POS_W'($urandom_range(0, 255)));
        end
        no_idle = 1'b0;
        wait_drained();
        for (k = 0; k < 6; k++) send_request(OP_FIND, POS_W'($urandom));
    endtask

    // Mostly allocate (find, then claim), with marks, frees and stray codes
    task automatic run_random_phase(input logic [CNT_W-1:0] count, input int n_items);
        int               lim;
        int               span;
        int               k;
        int               r;
        int               d;
        logic [1:0]       op;
        logic [POS_W-1:0] pos;
        write_cluster_count(count);
        lim  = active_limit();
        span = (lim == 0) ? 16 : ((lim < 512) ? lim : 512);
        for (k = 0; k < n_items; k++) begin
            if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_request(OP_FIND, POS_W'($urandom));
                if (last_alloc.ok) send_request(OP_SET, last_alloc.cluster);
            end else begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    pos = POS_W'($urandom_range(0, span - 1));
                end else if (r < 9) begin
                    pos = POS_W'($urandom);
                end else begin
                    // straddle the limit
                    d   = $urandom_range(0, 3);
                    pos = POS_W'((lim < 2) ? d : lim + d - 2);
                end
                r = $urandom_range(0, 99);
                if (r < 40)      op = OP_SET;
                else if (r < 70) op = OP_CLR;
                else if (r < 92) op = OP_FIND;
                else             op = OP_UNUSED;
                send_request(op, pos);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        for (int b = 0; b < BITMAP_BYTES; b++) usage_copy[b] = '0;
        cluster_count_copy = CNT_W'(COUNT_RESET);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_byte_boundary();
        test_count_extremes();
        test_backpressure();
        run_random_phase(CNT_W'(16384), 110);
        run_random_phase(CNT_W'(9), 110);
        run_random_phase(CNT_W'(64), 110);
        run_random_phase(CNT_W'(65), 110);
        run_random_phase(CNT_W'(100), 110);
        run_random_phase(CNT_W'(1), 110);
        run_random_phase(CNT_W'(300), 110);
        run_random_phase(CNT_W'(16383), 110);
        run_random_phase('1, 110);
        run_random_phase(CNT_W'(2000), 110);
        run_random_phase(CNT_W'(8), 110);
        run_random_phase(CNT_W'(16384), 110);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cba_pkg.sv
rtl/core/cba_ram.sv
rtl/core/cba_find.sv
rtl/core/cluster_bitmap_allocator.sv
dv/testbench.sv
